>>> sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the sequential permutation stop test.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

	localparam int NUM_STATS_DEF = 16;

	localparam int IDX_W   = 4;
	localparam int VAL_W   = 32;
	localparam int EXT_W   = 21;
	localparam int PERM_W  = 20;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [EXT_W-1:0]  EXT_MAX  = '1;
	localparam logic [PERM_W-1:0] PERM_MAX = '1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [2:0] REG_SEQ_EN    = 3'd0;
	localparam logic [2:0] REG_TOTAL     = 3'd1;
	localparam logic [2:0] REG_STEP_EXT  = 3'd2;
	localparam logic [2:0] REG_STEP_BASE = 3'd3;
	localparam logic [2:0] REG_UPPER     = 3'd4;
	localparam logic [2:0] REG_LOWER     = 3'd5;

	typedef struct packed {
		logic                     seq_en;
		logic [PERM_W-1:0]        total;
		logic signed [VAL_W-1:0]  step_ext;
		logic signed [VAL_W-1:0]  step_base;
		logic signed [VAL_W-1:0]  upper;
		logic signed [VAL_W-1:0]  lower;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  obs;
		logic signed [VAL_W-1:0]  llr;
		logic [EXT_W-1:0]         ext_cnt;
		logic [PERM_W-1:0]        perm_cnt;
		logic                     useless;
		logic                     signif;
	} entry_t;

endpackage

`default_nettype wire

>>> sv/sps_ifs.sv
// ----------------------------------------------------------------------------
// sps_ifs
// Valid/ready channels for requests and results of the stop test.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [3:0]  stat_index;
	logic signed [31:0] stat_value;
	logic        last_stat;

	modport source (output valid, opcode, stat_index, stat_value, last_stat, input ready);
	modport sink (input valid, opcode, stat_index, stat_value, last_stat, output ready);
endinterface

interface sps_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_index;
	logic [20:0] extreme_count;
	logic [19:0] permutation_count;
	logic        stopped_useless;
	logic        held_significant;
	logic        entry_stop;
	logic        all_stop;

	modport source (output valid, out_index, extreme_count, permutation_count,
		stopped_useless, held_significant, entry_stop, all_stop, input ready);
	modport sink (input valid, out_index, extreme_count, permutation_count,
		stopped_useless, held_significant, entry_stop, all_stop, output ready);
endinterface

`default_nettype wire

>>> sv/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/sps_cfg.sv
// ----------------------------------------------------------------------------
// sps_cfg
// APB register file holding the mode, permutation total, steps and thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sps_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [sps_pkg::DATA_W-1:0]  pwdata,
	output      logic [sps_pkg::DATA_W-1:0]  prdata,
	output      logic                        pready,
	output      sps_pkg::cfg_t               cfg
);
	import sps_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_sel;
	logic       wr_en;

	assign reg_sel = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SEQ_EN:    cfg_q.seq_en    <= pwdata[0];
				REG_TOTAL:     cfg_q.total     <= pwdata[PERM_W-1:0];
				REG_STEP_EXT:  cfg_q.step_ext  <= pwdata;
				REG_STEP_BASE: cfg_q.step_base <= pwdata;
				REG_UPPER:     cfg_q.upper     <= pwdata;
				REG_LOWER:     cfg_q.lower     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SEQ_EN:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.seq_en};
			REG_TOTAL:     prdata = {{(DATA_W-PERM_W){1'b0}}, cfg_q.total};
			REG_STEP_EXT:  prdata = cfg_q.step_ext;
			REG_STEP_BASE: prdata = cfg_q.step_base;
			REG_UPPER:     prdata = cfg_q.upper;
			REG_LOWER:     prdata = cfg_q.lower;
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/sps_core.sv
// ----------------------------------------------------------------------------
// sps_core
// Read-modify-write pipeline over the statistic table, with write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_core #(
	parameter int NUM_STATS = sps_pkg::NUM_STATS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sps_pkg::cfg_t cfg,
	sps_req_if.sink            req,
	sps_res_if.source          res
);
	import sps_pkg::*;

	localparam int AW = (NUM_STATS > 1) ? $clog2(NUM_STATS) : 1;
	localparam int EW = $bits(entry_t);

	// Request handshake and stage 1 (table read data arrives here).
	logic                    in_fire;
	logic                    s1_fire;
	logic                    vld_s1;
	logic                    op_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic                    last_s1;
	logic                    inr_s1;
	logic [AW-1:0]           addr_s1;

	logic                    in_range;
	logic [AW-1:0]           in_addr;

	logic [EW-1:0]           ram_rdata;
	entry_t                  ram_entry;
	entry_t                  cur;
	entry_t                  nxt;
	entry_t                  byp_q;
	logic                    byp_hit_q;
	logic                    vld_q [NUM_STATS];
	logic                    acc_q;

	logic                    extreme;
	logic signed [VAL_W+1:0] sum;
	logic signed [VAL_W-1:0] sat;
	logic                    stop;
	logic                    all;

	// Result register.
	logic                    res_valid_q;
	logic [IDX_W-1:0]        res_idx_q;
	logic [EXT_W-1:0]        res_ext_q;
	logic [PERM_W-1:0]       res_perm_q;
	logic                    res_use_q;
	logic                    res_sig_q;
	logic                    res_stop_q;
	logic                    res_all_q;

	assign s1_fire   = vld_s1 && (!res_valid_q || res.ready);
	assign req.ready = !vld_s1 || s1_fire;
	assign in_fire   = req.valid && req.ready;
	assign in_range  = {{(9-IDX_W){1'b0}}, req.stat_index} < 9'(NUM_STATS);
	assign in_addr   = AW'(req.stat_index);
	assign addr_s1   = AW'(idx_s1);

	sps_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_STATS)
	) u_table (
		.clk   (clk),
		.we    (s1_fire && inr_s1),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (in_fire),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	assign ram_entry = entry_t'(ram_rdata);

	always_comb begin
		if (byp_hit_q) begin
			cur = byp_q;
		end else if (inr_s1 && vld_q[addr_s1]) begin
			cur = ram_entry;
		end else begin
			cur          = '0;
			cur.obs      = ram_entry.obs;
			cur.ext_cnt  = EXT_W'(1);
		end
	end

	always_comb begin
		nxt     = cur;
		stop    = 1'b0;
		extreme = val_s1 >= cur.obs;
		sum     = (VAL_W+2)'(cur.llr) + (VAL_W+2)'(cfg.step_base)
			+ (extreme ? (VAL_W+2)'(cfg.step_ext) : '0);
		if (sum[VAL_W+1:VAL_W-1] == 3'b000 || sum[VAL_W+1:VAL_W-1] == 3'b111) begin
			sat = sum[VAL_W-1:0];
		end else if (sum[VAL_W+1]) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
		if (op_s1 == OP_LOAD) begin
			nxt          = '0;
			nxt.obs      = val_s1;
			nxt.ext_cnt  = EXT_W'(1);
		end else if (!cfg.seq_en || !cur.useless) begin
			if (extreme && cur.ext_cnt != EXT_MAX) begin
				nxt.ext_cnt = cur.ext_cnt + EXT_W'(1);
			end
			if (cur.perm_cnt != PERM_MAX) begin
				nxt.perm_cnt = cur.perm_cnt + PERM_W'(1);
			end
			if (cfg.seq_en) begin
				nxt.llr = sat;
				if (!cur.signif && sat <= cfg.lower) begin
					nxt.ext_cnt = {1'b0, cfg.total} + EXT_W'(1);
					nxt.useless = 1'b1;
					stop        = 1'b1;
				end else if (sat >= cfg.upper) begin
					nxt.signif = 1'b1;
				end
			end
		end else begin
			stop = 1'b1;
		end
		if (!inr_s1) begin
			stop = 1'b0;
		end
		all = (op_s1 == OP_UPDATE) && last_s1 && acc_q && stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			byp_hit_q   <= 1'b0;
			acc_q       <= 1'b1;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_STATS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (in_fire) begin
				vld_s1    <= 1'b1;
				byp_hit_q <= s1_fire && inr_s1 && (idx_s1 == req.stat_index);
			end else if (s1_fire) begin
				vld_s1 <= 1'b0;
			end
			if (s1_fire && inr_s1) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (s1_fire && op_s1 == OP_UPDATE) begin
				acc_q <= last_s1 ? 1'b1 : (acc_q && stop);
			end
			if (s1_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= req.opcode;
			idx_s1  <= req.stat_index;
			val_s1  <= req.stat_value;
			last_s1 <= req.last_stat;
			inr_s1  <= in_range;
			byp_q   <= nxt;
		end
		if (s1_fire) begin
			res_idx_q  <= idx_s1;
			res_ext_q  <= inr_s1 ? nxt.ext_cnt : '0;
			res_perm_q <= inr_s1 ? nxt.perm_cnt : '0;
			res_use_q  <= inr_s1 && nxt.useless;
			res_sig_q  <= inr_s1 && nxt.signif;
			res_stop_q <= stop;
			res_all_q  <= all;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.out_index         = res_idx_q;
	assign res.extreme_count     = res_ext_q;
	assign res.permutation_count = res_perm_q;
	assign res.stopped_useless   = res_use_q;
	assign res.held_significant  = res_sig_q;
	assign res.entry_stop        = res_stop_q;
	assign res.all_stop          = res_all_q;

	a_all_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_all_q |-> res_stop_q)
		else $error("all_stop without entry_stop");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_use_q && res_sig_q))
		else $error("entry both useless and significant");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && inr_s1 |=> vld_q[$past(addr_s1)])
		else $error("written entry not marked valid");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s1_fire |=> vld_s1 && $stable(idx_s1) && $stable(op_s1))
		else $error("stage 1 lost a request while stalled");

endmodule

`default_nettype wire

>>> sv/sequential_permutation_stop_test.sv
// ----------------------------------------------------------------------------
// sequential_permutation_stop_test
// Table of permutation-test statistics with sequential early stopping.
//
//   Channel  Kind        Handshake             Content
//   req      sink        valid/ready           opcode, stat_index, stat_value, last_stat
//   res      source      valid/ready           one result per request
//   APB      completer   psel/penable, pready  six configuration registers
//
// One request per cycle is sustained while results are taken; a taken request
// passes through stage 1, where the registered read of the table RAM arrives,
// and then into the result register.
// A write to the entry the next request reads is forwarded around the RAM.
// Reset clears per-entry valid bits at once; there is no clearing pass.
// A stalled result holds the result register, then stage 1, then req.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_permutation_stop_test #(
	parameter int NUM_STATS = sps_pkg::NUM_STATS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	sps_req_if.sink                         req,
	sps_res_if.source                       res,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sps_pkg::DATA_W-1:0] pwdata,
	output      logic [sps_pkg::DATA_W-1:0] prdata,
	output      logic                       pready
);
	import sps_pkg::*;

	cfg_t cfg;

	sps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sps_core #(
		.NUM_STATS (NUM_STATS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.res    (res)
	);

endmodule

`default_nettype wire
